### rtl/core/hkoc_pkg.sv
`timescale 1ns / 1ps

package hkoc_pkg;

	// field widths
	localparam int KEY_W    = 64;
	localparam int CNT_W    = 31;
	localparam int STATUS_W = 3;
	localparam int OUT_W    = 32;

	// key modulo unit: bits folded per cycle and folding steps per key
	localparam int MOD_BITS  = 8;
	localparam int MOD_STEPS = KEY_W / MOD_BITS;
	localparam int STEP_W    = $clog2(MOD_STEPS);

	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		STAT_INCREMENTED = 3'd0,
		STAT_INSERTED    = 3'd1,
		STAT_FULL        = 3'd2,
		STAT_FOUND       = 3'd3,
		STAT_NOT_FOUND   = 3'd4
	} status_t;

	// control states
	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_MOD,
		S_READ,
		S_LOOK
	} state_t;

endpackage

### rtl/core/hashed_key_occurrence_counter.sv
`timescale 1ns / 1ps
// flow: input transfer in S_IDLE, key modulo unit in S_MOD at 8 key bits a cycle,
// bucket row read in S_READ, then result load and row write-back in S_LOOK, which
// waits for a held result to leave the output register; the next input waits for S_IDLE
// a result waiting on the output register does not block the next input transfer
// reset: arst_n clears control state, then a clearing pass over all NUM_BUCKETS rows
// writes every bucket row invalid; no input is taken during the pass
module hashed_key_occurrence_counter #(
	parameter int NUM_BUCKETS     = 12,
	parameter int WAYS_PER_BUCKET = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [hkoc_pkg::KEY_W-1:0]          s_tdata,  // key
	input  logic                                s_tuser,  // func
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [hkoc_pkg::OUT_W-1:0]          m_tdata,  // count, one zero pad bit
	output logic [hkoc_pkg::STATUS_W-1:0]       m_tuser   // status
);
	import hkoc_pkg::*;

	localparam int BW     = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int WW     = (WAYS_PER_BUCKET > 1) ? $clog2(WAYS_PER_BUCKET) : 1;
	localparam int KEYS_W = WAYS_PER_BUCKET * KEY_W;
	localparam int CNTS_W = WAYS_PER_BUCKET * CNT_W;
	localparam int CNT_LO = KEYS_W;
	localparam int VLD_LO = KEYS_W + CNTS_W;
	localparam int ROW_W  = VLD_LO + WAYS_PER_BUCKET;

	localparam logic [BW:0]   NB_EXT   = (BW + 1)'(NUM_BUCKETS);
	localparam logic [BW-1:0] LAST_ROW = BW'(NUM_BUCKETS - 1);

	// bucket memory: valid bits, counts and keys of all ways in one row
	logic [ROW_W-1:0] mem [NUM_BUCKETS];

	state_t              state_q, state_d;
	logic [BW-1:0]       clr_q;
	logic [STEP_W-1:0]   step_q;
	logic                out_valid_q;
	logic                func_q;
	logic [KEY_W-1:0]    key_q;
	logic [KEY_W-1:0]    sh_q;
	logic [BW-1:0]       rem_q;
	logic [BW-1:0]       rem_d;
	logic [ROW_W-1:0]    rd_row_s1;
	status_t             out_status_q;
	logic [CNT_W-1:0]    out_count_q;

	logic                in_xfer;
	logic                out_load;
	logic                mem_we;
	logic [BW-1:0]       mem_waddr;
	logic [ROW_W-1:0]    mem_wdata;
	logic                hit_found;
	logic [WW-1:0]       hit_way;
	logic                free_found;
	logic [WW-1:0]       free_way;
	logic [CNT_W-1:0]    hit_cnt;
	logic [CNT_W-1:0]    inc_cnt;
	status_t             res_status;
	logic [CNT_W-1:0]    res_count;
	logic [ROW_W-1:0]    new_row;
	logic                row_upd;

	assign in_xfer  = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {{(OUT_W - CNT_W){1'b0}}, out_count_q};

	// fold the next key byte into the running remainder, one compare-subtract a bit
	always_comb begin
		logic [BW:0] t;
		rem_d = rem_q;
		for (int i = 0; i < MOD_BITS; i++) begin
			t = {rem_d, sh_q[KEY_W-1-i]};
			if (t >= NB_EXT) begin
				t = t - NB_EXT;
			end
			rem_d = t[BW-1:0];
		end
	end

	// way search over the bucket row, lowest way first
	always_comb begin
		hit_found  = 1'b0;
		hit_way    = '0;
		free_found = 1'b0;
		free_way   = '0;
		for (int w = WAYS_PER_BUCKET - 1; w >= 0; w--) begin
			if (rd_row_s1[VLD_LO + w]) begin
				if (rd_row_s1[w*KEY_W +: KEY_W] == key_q) begin
					hit_found = 1'b1;
					hit_way   = WW'(w);
				end
			end else begin
				free_found = 1'b1;
				free_way   = WW'(w);
			end
		end
	end

	// result and updated row
	always_comb begin
		hit_cnt    = rd_row_s1[CNT_LO + hit_way*CNT_W +: CNT_W];
		inc_cnt    = (hit_cnt == COUNT_MAX) ? hit_cnt : hit_cnt + CNT_W'(1);
		new_row    = rd_row_s1;
		row_upd    = 1'b0;
		res_count  = '0;
		res_status = STAT_NOT_FOUND;
		if (!func_q) begin
			if (hit_found) begin
				new_row[CNT_LO + hit_way*CNT_W +: CNT_W] = inc_cnt;
				row_upd    = 1'b1;
				res_count  = inc_cnt;
				res_status = STAT_INCREMENTED;
			end else if (free_found) begin
				new_row[free_way*KEY_W +: KEY_W]           = key_q;
				new_row[CNT_LO + free_way*CNT_W +: CNT_W]  = CNT_W'(1);
				new_row[VLD_LO + free_way]                 = 1'b1;
				row_upd    = 1'b1;
				res_count  = CNT_W'(1);
				res_status = STAT_INSERTED;
			end else begin
				res_status = STAT_FULL;
			end
		end else begin
			if (hit_found) begin
				res_count  = hit_cnt;
				res_status = STAT_FOUND;
			end
		end
	end

	// next state and control outputs
	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		out_load  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = rem_q;
		mem_wdata = new_row;
		case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
				if (clr_q == LAST_ROW) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = S_MOD;
				end
			end
			S_MOD: begin
				if (step_q == STEP_W'(MOD_STEPS - 1)) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				state_d = S_LOOK;
			end
			S_LOOK: begin
				if (!out_valid_q || m_tready) begin
					out_load = 1'b1;
					mem_we   = row_upd;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + BW'(1);
			end
			if (in_xfer) begin
				step_q <= '0;
			end else if (state_q == S_MOD) begin
				step_q <= step_q + STEP_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item payload, key modulo datapath and output payload
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			func_q <= s_tuser;
			key_q  <= s_tdata;
			sh_q   <= s_tdata;
			rem_q  <= '0;
		end else if (state_q == S_MOD) begin
			sh_q  <= sh_q << MOD_BITS;
			rem_q <= rem_d;
		end
		if (out_load) begin
			out_status_q <= res_status;
			out_count_q  <= res_count;
		end
	end

	// bucket memory write port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	// bucket memory read port, registered data
	always_ff @(posedge clk) begin
		if (state_q == S_READ) begin
			rd_row_s1 <= mem[rem_q];
		end
	end

endmodule

### test/tb_hashed_key_occurrence_counter.sv
`timescale 1ns / 1ps

module tb_hashed_key_occurrence_counter;
	import hkoc_pkg::*;

	localparam int NUM_BUCKETS     = 12;
	localparam int WAYS_PER_BUCKET = 4;
	localparam int NUM_ENTRIES     = NUM_BUCKETS * WAYS_PER_BUCKET;
	localparam int RAND_ITEMS      = 1850;
	localparam int KEYS_PER_BUCKET = 6;
	localparam int HOLD_LEN        = 400;
	localparam int CYCLE_LIMIT     = 400000;
	localparam int MAX_PRINTS      = 60;

	// request kinds carried on s_tuser
	localparam logic FN_COUNT = 1'b0;
	localparam logic FN_QUERY = 1'b1;

	typedef struct {
		logic             func;
		logic [KEY_W-1:0] key;
		int unsigned      tx_idle;
		int unsigned      rx_idle;
		bit               drain;
	} req_t;

	typedef struct {
		status_t          status;
		logic [CNT_W-1:0] count;
	} tally_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [KEY_W-1:0]     s_tdata = '0;
	logic                 s_tuser = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [OUT_W-1:0]     m_tdata;
	logic [STATUS_W-1:0]  m_tuser;

	// shadow copy of the bucket table
	logic [KEY_W-1:0]     shadow_key [NUM_ENTRIES];
	logic [CNT_W-1:0]     shadow_cnt [NUM_ENTRIES];
	bit                   shadow_used [NUM_ENTRIES];

	req_t                 pending_reqs [$];
	tally_t               expected_tallies [$];
	logic [KEY_W-1:0]     key_pool [$];
	req_t                 next_req;
	tally_t               got_tally;
	int unsigned          rx_idle_pct = 78;
	int unsigned          n_accepted = 0;
	int unsigned          hold_at = 0;
	int unsigned          hold_left = 0;
	bit                   hold_done = 1'b0;
	int unsigned          cycle_cnt = 0;
	int unsigned          n_errors = 0;

	hashed_key_occurrence_counter #(
		.NUM_BUCKETS    (NUM_BUCKETS),
		.WAYS_PER_BUCKET(WAYS_PER_BUCKET)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
	end

	task automatic report_error(input string msg);
		n_errors++;
		if (n_errors <= MAX_PRINTS)
			$display("mismatch at cycle %0d: %s", cycle_cnt, msg);
	endtask

	// lookup, increment or insert on the shadow table; returns the expected result
	function automatic tally_t tally_key(input logic func, input logic [KEY_W-1:0] key);
		int     bucket;
		int     hit;
		int     vacant;
		int     e;
		tally_t r;
		bucket = int'(key % 64'(NUM_BUCKETS));
		hit = -1;
		vacant = -1;
		for (int w = 0; w < WAYS_PER_BUCKET; w++) begin
			e = bucket * WAYS_PER_BUCKET + w;
			if (shadow_used[e]) begin
				if (hit < 0 && shadow_key[e] == key)
					hit = e;
			end else if (vacant < 0) begin
				vacant = e;
			end
		end
		r.count = '0;
		if (func == FN_COUNT) begin
			if (hit >= 0) begin
				if (shadow_cnt[hit] != COUNT_MAX)
					shadow_cnt[hit] = shadow_cnt[hit] + 1'b1;
				r.count = shadow_cnt[hit];
				r.status = STAT_INCREMENTED;
			end else if (vacant >= 0) begin
				shadow_key[vacant] = key;
				shadow_cnt[vacant] = CNT_W'(1);
				shadow_used[vacant] = 1'b1;
				r.count = CNT_W'(1);
				r.status = STAT_INSERTED;
			end else begin
				r.status = STAT_FULL;
			end
		end else begin
			if (hit >= 0) begin
				r.count = shadow_cnt[hit];
				r.status = STAT_FOUND;
			end else begin
				r.status = STAT_NOT_FOUND;
			end
		end
		return r;
	endfunction

	task automatic add_req(input logic func, input logic [KEY_W-1:0] key,
			input int unsigned tx_idle, input int unsigned rx_idle, input bit drain);
		req_t r;
		r.func = func;
		r.key = key;
		r.tx_idle = tx_idle;
		r.rx_idle = rx_idle;
		r.drain = drain;
		pending_reqs.push_back(r);
	endtask

	// input driver: predicts each accepted transfer, then offers the next request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid) begin
				expected_tallies.push_back(tally_key(s_tuser, s_tdata));
				n_accepted <= n_accepted + 1;
			end
			if (pending_reqs.size() != 0
					&& !(pending_reqs[0].drain && (expected_tallies.size() != 0 || s_tvalid))
					&& $urandom_range(99) >= pending_reqs[0].tx_idle) begin
				next_req = pending_reqs.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= next_req.key;
				s_tuser <= next_req.func;
				rx_idle_pct <= next_req.rx_idle;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// output ready: random backpressure plus one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && hold_at != 0 && n_accepted >= hold_at) begin
			m_tready <= 1'b0;
			hold_left <= HOLD_LEN;
			hold_done <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// result monitor: compare each transfer with the oldest expected tally
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_tallies.size() == 0) begin
				report_error($sformatf("unexpected result status %0d count %0d",
					m_tuser, m_tdata));
			end else begin
				got_tally = expected_tallies.pop_front();
				if (m_tuser !== got_tally.status)
					report_error($sformatf("status %0d, expected %0d",
						m_tuser, got_tally.status));
				if (m_tdata !== {{(OUT_W-CNT_W){1'b0}}, got_tally.count})
					report_error($sformatf("count 0x%08h, expected 0x%08h",
						m_tdata, got_tally.count));
			end
		end
	end

	// timeout
	initial begin
		wait (cycle_cnt >= CYCLE_LIMIT);
		$display("TB_ERROR");
		$finish;
	end

	// stimulus and end of run
	initial begin
		logic [KEY_W-1:0] k;
		int unsigned      tx;
		int unsigned      rx;
		int unsigned      pick;
		int unsigned      n_directed;
		logic             fn;

		for (int e = 0; e < NUM_ENTRIES; e++) begin
			shadow_key[e] = '0;
			shadow_cnt[e] = '0;
			shadow_used[e] = 1'b0;
		end

		// directed: misses, insert, increment, hit, extreme keys, full bucket
		add_req(FN_QUERY, 64'd0, 35, 78, 1'b0);
		add_req(FN_COUNT, 64'd0, 35, 78, 1'b0);
		add_req(FN_COUNT, 64'd0, 35, 78, 1'b0);
		add_req(FN_QUERY, 64'd0, 35, 78, 1'b0);
		add_req(FN_COUNT, 64'hFFFF_FFFF_FFFF_FFFF, 35, 78, 1'b0);
		add_req(FN_QUERY, 64'hFFFF_FFFF_FFFF_FFFF, 35, 78, 1'b0);
		add_req(FN_COUNT, 64'd12, 35, 78, 1'b0);
		add_req(FN_COUNT, 64'd24, 35, 78, 1'b0);
		add_req(FN_COUNT, 64'd36, 35, 78, 1'b0);
		add_req(FN_COUNT, 64'd48, 35, 78, 1'b0);
		add_req(FN_QUERY, 64'd48, 35, 78, 1'b1);
		add_req(FN_COUNT, 64'd12, 35, 78, 1'b0);
		add_req(FN_QUERY, 64'd36, 35, 78, 1'b0);
		add_req(FN_COUNT, 64'hAAAA_AAAA_AAAA_AAAA, 35, 78, 1'b0);
		add_req(FN_COUNT, 64'h5555_5555_5555_5555, 35, 78, 1'b0);
		add_req(FN_QUERY, 64'h5555_5555_5555_5555, 35, 78, 1'b0);
		add_req(FN_QUERY, 64'hFFFF_FFFF_FFFF_FFFE, 35, 78, 1'b0);
		add_req(FN_COUNT, 64'h8000_0000_0000_0000, 35, 78, 1'b0);
		n_directed = pending_reqs.size();

		// key pool: two more keys per bucket than there are ways
		for (int b = 0; b < NUM_BUCKETS; b++) begin
			for (int j = 0; j < KEYS_PER_BUCKET; j++) begin
				k = {$urandom, $urandom};
				k[KEY_W-1] = 1'b0;
				k = k - (k % 64'(NUM_BUCKETS)) + 64'(b);
				key_pool.push_back(k);
			end
		end

		// random: mostly pool keys so counts build up, some arbitrary and edge keys
		for (int i = 0; i < RAND_ITEMS; i++) begin
			if (i < RAND_ITEMS / 3) begin
				tx = 35;
				rx = 78;
			end else if (i < 2 * RAND_ITEMS / 3) begin
				tx = 78;
				rx = 35;
			end else begin
				tx = 0;
				rx = 0;
			end
			pick = $urandom_range(99);
			if (pick < 75)
				k = key_pool[$urandom_range(key_pool.size() - 1)];
			else if (pick < 92)
				k = {$urandom, $urandom};
			else if (pick < 96)
				k = 64'($urandom_range(40));
			else
				k = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(40));
			fn = ($urandom_range(99) < 55) ? FN_COUNT : FN_QUERY;
			add_req(fn, k, tx, rx, (i == RAND_ITEMS / 3) || (i == 2 * RAND_ITEMS / 3)
				|| ($urandom_range(199) == 0));
		end

		// long receiver stall during the phase without idling
		hold_at = n_directed + 2 * RAND_ITEMS / 3 + 60;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() != 0 || s_tvalid)
			@(posedge clk);
		while (expected_tallies.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (n_errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
